[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_NORST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_NEXT_NORST(lbl, ante, cons)

`endif

`endif

[hw/rtl/salct_pkg.sv]
// ----------------------------------------------------------------------------
// salct_pkg
// Shared constants and types of the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salct_pkg;

   localparam int ADDR_W     = 48;
   localparam int TAG_W      = 48;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // access kinds (load 0 and store 1 need no special handling)
   localparam logic [1:0] MODE_MODIFY = 2'd2;
   localparam logic [1:0] MODE_IFETCH = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   // register reset values
   localparam logic [2:0] RST_SET_BITS   = 3'd6;
   localparam logic [5:0] RST_BLOCK_BITS = 6'd4;
   localparam logic [2:0] RST_WAYS       = 3'd4;

   typedef struct packed {
      logic hit;
      logic evicted;
   } lkp_status_type;

endpackage

[hw/rtl/salct_addr_split.sv]
// ----------------------------------------------------------------------------
// salct_addr_split
// Splits a byte address into set index and tag under the current geometry.
// ----------------------------------------------------------------------------
module salct_addr_split #(
   parameter int SET_INDEX_BITS = 6,
   parameter int SET_W          = 6
) (
   input  logic [salct_pkg::ADDR_W-1:0] address,
   input  logic [2:0]                   set_bits,
   input  logic [5:0]                   block_bits,
   output logic [SET_W-1:0]             set_idx,
   output logic [salct_pkg::TAG_W-1:0]  tag
);

   logic [3:0]                   s_eff;
   logic [6:0]                   sb_sum;
   logic [salct_pkg::ADDR_W-1:0] shifted;
   logic [SET_W-1:0]             set_mask;

   // oversized set_bits clamps to the built index width
   assign s_eff = ({1'b0, set_bits} > 4'(SET_INDEX_BITS)) ? 4'(SET_INDEX_BITS)
                                                          : {1'b0, set_bits};
   assign sb_sum = {3'b000, s_eff} + {1'b0, block_bits};

   // shifts past the address width give zero, as required for huge offsets
   assign shifted  = address >> block_bits;
   assign set_mask = ~({SET_W{1'b1}} << s_eff);
   assign set_idx  = shifted[SET_W-1:0] & set_mask;
   assign tag      = salct_pkg::TAG_W'(address >> sb_sum);

endmodule

[hw/rtl/salct_set_store.sv]
// ----------------------------------------------------------------------------
// salct_set_store
// Per-set tag and rank rows in memory, valid bits in flops, write forwarding.
// ----------------------------------------------------------------------------
module salct_set_store #(
   parameter int WAYS     = 4,
   parameter int NUM_SETS = 64,
   parameter int SET_W    = 6,
   parameter int RANK_W   = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [SET_W-1:0]                      rd_set,
   input  logic [SET_W-1:0]                      lk_set,
   input  logic                                  wr_en,
   input  logic [SET_W-1:0]                      wr_set,
   input  logic [WAYS-1:0][salct_pkg::TAG_W-1:0] wr_tags,
   input  logic [WAYS-1:0][RANK_W-1:0]           wr_ranks,
   input  logic [WAYS-1:0]                       wr_valid,
   input  logic                                  ranks_clear,
   output logic [WAYS-1:0][salct_pkg::TAG_W-1:0] row_tags,
   output logic [WAYS-1:0][RANK_W-1:0]           row_ranks,
   output logic [WAYS-1:0]                       row_valid
);

   logic [WAYS-1:0][salct_pkg::TAG_W-1:0] tag_mem  [NUM_SETS];
   logic [WAYS-1:0][RANK_W-1:0]           rank_mem [NUM_SETS];
   logic [WAYS-1:0]                       valid_ff   [NUM_SETS];
   logic                                  rank_ok_ff [NUM_SETS];

   logic [WAYS-1:0][salct_pkg::TAG_W-1:0] rd_tags_ff;
   logic [WAYS-1:0][RANK_W-1:0]           rd_ranks_ff;
   logic [WAYS-1:0][salct_pkg::TAG_W-1:0] fwd_tags_ff;
   logic [WAYS-1:0][RANK_W-1:0]           fwd_ranks_ff;
   logic                                  fwd_ff;
   logic                                  fwd_in;
   logic [WAYS-1:0][RANK_W-1:0]           ident_ranks;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         ident_ranks[w] = RANK_W'(w);
      end
   end

   // read-before-write memory; a same-set write on the read edge is forwarded
   assign fwd_in = wr_en && (wr_set == rd_set);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_set]  <= wr_tags;
         rank_mem[wr_set] <= wr_ranks;
      end
      if (rd_en) begin
         rd_tags_ff   <= tag_mem[rd_set];
         rd_ranks_ff  <= rank_mem[rd_set];
         fwd_tags_ff  <= wr_tags;
         fwd_ranks_ff <= wr_ranks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s]   <= '0;
            rank_ok_ff[s] <= 1'b0;
         end
      end else begin
         if (rd_en) begin
            fwd_ff <= fwd_in;
         end
         // associativity change: every row falls back to identity ranks
         if (ranks_clear) begin
            for (int s = 0; s < NUM_SETS; s++) begin
               rank_ok_ff[s] <= 1'b0;
            end
         end
         if (wr_en) begin
            valid_ff[wr_set]   <= wr_valid;
            rank_ok_ff[wr_set] <= 1'b1;
         end
      end
   end

   assign row_tags  = fwd_ff ? fwd_tags_ff : rd_tags_ff;
   assign row_ranks = fwd_ff ? fwd_ranks_ff
                             : (rank_ok_ff[lk_set] ? rd_ranks_ff : ident_ranks);
   assign row_valid = valid_ff[lk_set];

endmodule

[hw/rtl/salct_lookup.sv]
// ----------------------------------------------------------------------------
// salct_lookup
// Tag compare, victim pick and LRU rank update for one set row.
// ----------------------------------------------------------------------------
module salct_lookup #(
   parameter int WAYS   = 4,
   parameter int RANK_W = 2,
   parameter int ACT_W  = 3
) (
   input  logic [2:0]                            ways_in_use,
   input  logic [salct_pkg::TAG_W-1:0]           tag,
   input  logic [WAYS-1:0][salct_pkg::TAG_W-1:0] row_tags,
   input  logic [WAYS-1:0][RANK_W-1:0]           row_ranks,
   input  logic [WAYS-1:0]                       row_valid,
   output logic [WAYS-1:0][salct_pkg::TAG_W-1:0] new_tags,
   output logic [WAYS-1:0][RANK_W-1:0]           new_ranks,
   output logic [WAYS-1:0]                       new_valid,
   output salct_pkg::lkp_status_type             status
);

   logic [4:0]       wu;
   logic [4:0]       act_wide;
   logic [ACT_W-1:0] act;
   logic [WAYS-1:0]  en;
   logic [WAYS-1:0]  match;
   logic [RANK_W-1:0] hit_way;
   logic [RANK_W-1:0] victim;
   logic [RANK_W-1:0] sel;
   logic [RANK_W-1:0] old_rank;
   logic              hit;

   // out-of-range associativity clamps into 1..WAYS
   assign wu = {2'b00, ways_in_use};
   always_comb begin
      if (wu == 5'd0) begin
         act_wide = 5'd1;
      end else if (wu > 5'(WAYS)) begin
         act_wide = 5'(WAYS);
      end else begin
         act_wide = wu;
      end
   end
   assign act = ACT_W'(act_wide);

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         en[w]    = (ACT_W'(w) < act);
         match[w] = en[w] && row_valid[w] && (row_tags[w] == tag);
      end
   end

   // lowest matching way wins; lowest rank-0 way is the victim
   always_comb begin
      hit_way = '0;
      victim  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = RANK_W'(w);
         end
         if (en[w] && (row_ranks[w] == '0)) begin
            victim = RANK_W'(w);
         end
      end
   end

   assign hit      = |match;
   assign sel      = hit ? hit_way : victim;
   assign old_rank = row_ranks[sel];

   always_comb begin
      new_ranks = row_ranks;
      for (int w = 0; w < WAYS; w++) begin
         if (en[w] && (row_ranks[w] > old_rank)) begin
            new_ranks[w] = row_ranks[w] - 1'b1;
         end
      end
      new_ranks[sel] = RANK_W'(act - ACT_W'(1));

      new_tags  = row_tags;
      new_valid = row_valid;
      if (!hit) begin
         new_tags[sel]  = tag;
         new_valid[sel] = 1'b1;
      end
   end

   assign status.hit     = hit;
   assign status.evicted = !hit && row_valid[sel];

endmodule

[hw/rtl/set_assoc_lru_cache_tracker_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_unit
// Set-associative cache hit/miss tracker with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one memory access per item (mode, 48-bit byte address).
//            Modes: load, store, modify (extra hit for its store half),
//            instruction fetch (no result, no state change).
//   rsp_*  : one result item per non-fetch access, in order: hit, evicted,
//            modify_hit and the running hit/miss/eviction totals (wrap at 32b).
//   csr_*  : set_bits, block_bits, ways_in_use; write only while idle.
//            A ways_in_use write restores identity LRU ranks in every set.
// Pipeline: an accepted item sits in the input register, its set row is
//   read, then the lookup lands in the result register.
// Throughput: one item per cycle unless rsp_stall holds a result; the
//   single read/write port pair of the set memories handles it, a
//   same-set back-to-back access is forwarded.
// Reset: valid bits, rank-valid flags and totals clear under reset; no
//   clearing pass, so items are taken right after reset.
// Stall: rsp_stall on a pending result freezes the whole pipe and raises
//   req_stall in the same cycle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker_unit #(
   parameter int SET_INDEX_BITS = 6,
   parameter int WAYS           = 4
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [salct_pkg::ADDR_W-1:0]        req_address,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic                                rsp_modify_hit,
   output logic [salct_pkg::CNT_W-1:0]         rsp_hit_count,
   output logic [salct_pkg::CNT_W-1:0]         rsp_miss_count,
   output logic [salct_pkg::CNT_W-1:0]         rsp_eviction_count,

   input  logic                                csr_we,
   input  logic [salct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salct_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   `include "assert_macros.svh"

   localparam int NUM_SETS = 1 << SET_INDEX_BITS;
   localparam int SET_W    = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ACT_W    = $clog2(WAYS + 1);

   // ---- configuration registers
   logic [2:0] set_bits_ff,   set_bits_in;
   logic [5:0] block_bits_ff, block_bits_in;
   logic [2:0] ways_ff,       ways_in;
   logic       ranks_clear;

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      ranks_clear   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            salct_pkg::CSR_SET_BITS: begin
               set_bits_in = csr_wdata[2:0];
            end
            salct_pkg::CSR_BLOCK_BITS: begin
               block_bits_in = csr_wdata;
            end
            salct_pkg::CSR_WAYS: begin
               ways_in     = csr_wdata[2:0];
               ranks_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salct_pkg::RST_SET_BITS;
         block_bits_ff <= salct_pkg::RST_BLOCK_BITS;
         ways_ff       <= salct_pkg::RST_WAYS;
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   // ---- pipe control: everything moves unless a result is held
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---- stage 1: input register and address split
   logic                         s1_valid_ff;
   logic [1:0]                   s1_mode_ff;
   logic [salct_pkg::ADDR_W-1:0] s1_addr_ff;
   logic [SET_W-1:0]             s1_set;
   logic [salct_pkg::TAG_W-1:0]  s1_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= req_mode;
         s1_addr_ff <= req_address;
      end
   end

   salct_addr_split #(
      .SET_INDEX_BITS (SET_INDEX_BITS),
      .SET_W          (SET_W)
   ) u_split (
      .address    (s1_addr_ff),
      .set_bits   (set_bits_ff),
      .block_bits (block_bits_ff),
      .set_idx    (s1_set),
      .tag        (s1_tag)
   );

   // ---- stage 2: set row read back, lookup and state write
   logic                        s2_valid_ff;
   logic [1:0]                  s2_mode_ff;
   logic [SET_W-1:0]            s2_set_ff;
   logic [salct_pkg::TAG_W-1:0] s2_tag_ff;
   logic                        s2_active;
   logic                        s2_write;
   logic                        s2_modify;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mode_ff <= s1_mode_ff;
         s2_set_ff  <= s1_set;
         s2_tag_ff  <= s1_tag;
      end
   end

   // fetches flow through but touch nothing
   assign s2_active = s2_valid_ff && (s2_mode_ff != salct_pkg::MODE_IFETCH);
   assign s2_write  = s2_active && advance;
   assign s2_modify = (s2_mode_ff == salct_pkg::MODE_MODIFY);

   logic [WAYS-1:0][salct_pkg::TAG_W-1:0] row_tags,  new_tags;
   logic [WAYS-1:0][RANK_W-1:0]           row_ranks, new_ranks;
   logic [WAYS-1:0]                       row_valid, new_valid;
   salct_pkg::lkp_status_type             status;

   salct_set_store #(
      .WAYS     (WAYS),
      .NUM_SETS (NUM_SETS),
      .SET_W    (SET_W),
      .RANK_W   (RANK_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (advance),
      .rd_set      (s1_set),
      .lk_set      (s2_set_ff),
      .wr_en       (s2_write),
      .wr_set      (s2_set_ff),
      .wr_tags     (new_tags),
      .wr_ranks    (new_ranks),
      .wr_valid    (new_valid),
      .ranks_clear (ranks_clear),
      .row_tags    (row_tags),
      .row_ranks   (row_ranks),
      .row_valid   (row_valid)
   );

   salct_lookup #(
      .WAYS   (WAYS),
      .RANK_W (RANK_W),
      .ACT_W  (ACT_W)
   ) u_lookup (
      .ways_in_use (ways_ff),
      .tag         (s2_tag_ff),
      .row_tags    (row_tags),
      .row_ranks   (row_ranks),
      .row_valid   (row_valid),
      .new_tags    (new_tags),
      .new_ranks   (new_ranks),
      .new_valid   (new_valid),
      .status      (status)
   );

   // ---- running totals
   logic [salct_pkg::CNT_W-1:0] hits_ff,   hits_in;
   logic [salct_pkg::CNT_W-1:0] misses_ff, misses_in;
   logic [salct_pkg::CNT_W-1:0] evicts_ff, evicts_in;

   // a modify adds its store-half hit on top of the lookup result
   assign hits_in   = hits_ff + salct_pkg::CNT_W'(status.hit)
                              + salct_pkg::CNT_W'(s2_modify);
   assign misses_in = misses_ff + salct_pkg::CNT_W'(!status.hit);
   assign evicts_in = evicts_ff + salct_pkg::CNT_W'(status.evicted);

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (s2_write) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   // ---- result register
   logic                        rsp_hit_ff;
   logic                        rsp_evicted_ff;
   logic                        rsp_modify_ff;
   logic [salct_pkg::CNT_W-1:0] rsp_hits_ff;
   logic [salct_pkg::CNT_W-1:0] rsp_misses_ff;
   logic [salct_pkg::CNT_W-1:0] rsp_evicts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_active;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_write) begin
         rsp_hit_ff     <= status.hit;
         rsp_evicted_ff <= status.evicted;
         rsp_modify_ff  <= s2_modify;
         rsp_hits_ff    <= hits_in;
         rsp_misses_ff  <= misses_in;
         rsp_evicts_ff  <= evicts_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_modify_hit     = rsp_modify_ff;
   assign rsp_hit_count      = rsp_hits_ff;
   assign rsp_miss_count     = rsp_misses_ff;
   assign rsp_eviction_count = rsp_evicts_ff;

   // ---- checks
   `ASSERT_IMPL(a_stall_reaches_req, rsp_valid_ff && rsp_stall, req_stall)
   `ASSERT_NEXT(a_s2_held_on_stall, rsp_valid_ff && rsp_stall, s2_valid_ff == $past(s2_valid_ff))
   `ASSERT_NEXT(a_fetch_no_result, s2_valid_ff && !s2_active && advance, !rsp_valid_ff)
   `ASSERT_NEXT_NORST(a_reset_clears_rsp, reset, !rsp_valid_ff)

endmodule

[dv/set_assoc_lru_cache_tracker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_checker
// Watches the access, result and register ports of the cache tracker. Keeps
// its own copy of the tags, valid bits, LRU ranks and totals, predicts one
// result per non-fetch access and compares each result field by field.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker_checker #(
   parameter int SET_INDEX_BITS = 6,
   parameter int WAYS           = 4
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [salct_pkg::ADDR_W-1:0]        req_address,

   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_hit,
   input  logic                                rsp_evicted,
   input  logic                                rsp_modify_hit,
   input  logic [salct_pkg::CNT_W-1:0]         rsp_hit_count,
   input  logic [salct_pkg::CNT_W-1:0]         rsp_miss_count,
   input  logic [salct_pkg::CNT_W-1:0]         rsp_eviction_count,

   input  logic                                csr_we,
   input  logic [salct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [salct_pkg::CSR_DATA_W-1:0]    csr_wdata,

   output int                                  fail_count,
   output int                                  outstanding
);

   localparam int SETS  = 1 << SET_INDEX_BITS;
   localparam int LINES = SETS * WAYS;

   typedef struct packed {
      logic                        hit;
      logic                        evicted;
      logic                        modify_hit;
      logic [salct_pkg::CNT_W-1:0] hit_count;
      logic [salct_pkg::CNT_W-1:0] miss_count;
      logic [salct_pkg::CNT_W-1:0] eviction_count;
   } access_result_type;

   bit                          line_valid [LINES];
   logic [salct_pkg::TAG_W-1:0] line_tag   [LINES];
   int unsigned                 lru_rank   [LINES];
   logic [salct_pkg::CNT_W-1:0] hits, misses, evictions;
   logic [2:0]                  cfg_set_bits;
   logic [5:0]                  cfg_block_bits;
   logic [2:0]                  cfg_ways;

   access_result_type           pending_results [$];
   int                          errors = 0;

   function automatic void restore_ranks();
      for (int i = 0; i < LINES; i++)
         lru_rank[i] = i % WAYS;
   endfunction

   function automatic int unsigned ways_active();
      int unsigned e;
      e = cfg_ways;
      if (e < 1) e = 1;
      if (e > WAYS) e = WAYS;
      return e;
   endfunction

   // way w becomes most recent; ranks above it slide down
   function automatic void make_most_recent(int unsigned base, int unsigned w, int unsigned e);
      int unsigned old;
      old = lru_rank[base + w];
      for (int unsigned i = 0; i < e; i++)
         if (lru_rank[base + i] > old)
            lru_rank[base + i]--;
      lru_rank[base + w] = e - 1;
   endfunction

   function automatic access_result_type lookup_access(logic [1:0] mode,
                                                       logic [salct_pkg::ADDR_W-1:0] addr);
      int unsigned       s, b, e, set_idx, base, victim;
      logic [63:0]       a64, tag64;
      bit                found;
      access_result_type r;
      s = (cfg_set_bits > SET_INDEX_BITS) ? SET_INDEX_BITS : cfg_set_bits;
      b = cfg_block_bits;
      e = ways_active();
      a64 = 64'(addr);
      set_idx = (b < 64) ? int'((a64 >> b) & ((64'd1 << s) - 64'd1)) : 0;
      tag64 = (s + b < 64) ? (a64 >> (s + b)) : 64'd0;
      base = (set_idx % SETS) * WAYS;
      found = 1'b0;
      victim = 0;
      r = '0;
      for (int unsigned i = 0; i < e; i++) begin
         if (!found && line_valid[base + i]
             && line_tag[base + i] == tag64[salct_pkg::TAG_W-1:0]) begin
            found = 1'b1;
            make_most_recent(base, i, e);
         end
      end
      r.hit = found;
      if (found) begin
         hits++;
      end else begin
         // lowest-numbered way with rank 0, way 0 if none
         for (int i = int'(e) - 1; i >= 0; i--)
            if (lru_rank[base + i] == 0)
               victim = i;
         r.evicted = line_valid[base + victim];
         line_valid[base + victim] = 1'b1;
         line_tag[base + victim] = tag64[salct_pkg::TAG_W-1:0];
         make_most_recent(base, victim, e);
         misses++;
         if (r.evicted)
            evictions++;
      end
      if (mode == salct_pkg::MODE_MODIFY) begin
         hits++;
         r.modify_hit = 1'b1;
      end
      r.hit_count = hits;
      r.miss_count = misses;
      r.eviction_count = evictions;
      return r;
   endfunction

   function automatic void check_field(string name, logic [salct_pkg::CNT_W-1:0] exp,
                                       logic [salct_pkg::CNT_W-1:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      access_result_type exp;
      if (reset) begin
         cfg_set_bits = salct_pkg::RST_SET_BITS;
         cfg_block_bits = salct_pkg::RST_BLOCK_BITS;
         cfg_ways = salct_pkg::RST_WAYS;
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i] = '0;
         end
         restore_ranks();
         hits = '0;
         misses = '0;
         evictions = '0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               salct_pkg::CSR_SET_BITS:   cfg_set_bits = csr_wdata[2:0];
               salct_pkg::CSR_BLOCK_BITS: cfg_block_bits = csr_wdata[5:0];
               salct_pkg::CSR_WAYS: begin
                  cfg_ways = csr_wdata[2:0];
                  restore_ranks();
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result item with no access outstanding");
               errors++;
            end else begin
               exp = pending_results.pop_front();
               check_field("hit", 32'(exp.hit), 32'(rsp_hit));
               check_field("evicted", 32'(exp.evicted), 32'(rsp_evicted));
               check_field("modify_hit", 32'(exp.modify_hit), 32'(rsp_modify_hit));
               check_field("hit_count", exp.hit_count, rsp_hit_count);
               check_field("miss_count", exp.miss_count, rsp_miss_count);
               check_field("eviction_count", exp.eviction_count, rsp_eviction_count);
            end
         end
         if (req_valid && !req_stall && req_mode != salct_pkg::MODE_IFETCH)
            pending_results.push_back(lookup_access(req_mode, req_address));
      end
      fail_count <= errors;
      outstanding <= pending_results.size();
   end

endmodule

[dv/tb_set_assoc_lru_cache_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tracker_unit
// Drives memory accesses and cache geometry writes into the LRU cache tracker
// under varying handshake pressure; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tracker_unit;

   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 8;     // pipe is three deep, leave margin
   localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake or register write
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_ACCESSES  = 85;
   localparam int HOT_SLOTS       = 16;

   // load and store behave alike; the package only names the special kinds
   localparam logic [1:0]                      MODE_LOAD  = 2'd0;
   localparam logic [1:0]                      MODE_STORE = 2'd1;
   localparam logic [salct_pkg::CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;   // unmapped index

   logic                             clock;
   logic                             reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_mode = MODE_LOAD;
   logic [salct_pkg::ADDR_W-1:0]     req_address = '0;

   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_hit, rsp_evicted, rsp_modify_hit;
   logic [salct_pkg::CNT_W-1:0]      rsp_hit_count, rsp_miss_count, rsp_eviction_count;

   logic                             csr_we = 1'b0;
   logic [salct_pkg::CSR_IDX_W-1:0]  csr_index = salct_pkg::CSR_SET_BITS;
   logic [salct_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                               fail_count;
   int                               outstanding;

   // knobs shared with the receiver process (written with NBAs)
   int                               rsp_idle_pct = 0;
   bit                               hold_off_go = 1'b0;

   // sender-side state
   int                               req_idle_pct = 0;
   logic [2:0]                       cur_set_bits = salct_pkg::RST_SET_BITS;
   logic [5:0]                       cur_block_bits = salct_pkg::RST_BLOCK_BITS;
   logic [salct_pkg::ADDR_W-1:0]     hot_addr [HOT_SLOTS];
   int                               accesses_sent = 0;
   int                               fetches_sent = 0;
   int                               geometries = 0;

   set_assoc_lru_cache_tracker_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_evicted        (rsp_evicted),
      .rsp_modify_hit     (rsp_modify_hit),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_eviction_count (rsp_eviction_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   set_assoc_lru_cache_tracker_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_evicted        (rsp_evicted),
      .rsp_modify_hit     (rsp_modify_hit),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_eviction_count (rsp_eviction_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: random stall at rsp_idle_pct, plus one long hold-off on
   // request so the pipe backs up into req_stall while items keep coming.
   initial begin : result_side
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic logic [salct_pkg::ADDR_W-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[salct_pkg::ADDR_W-1:0];
   endfunction

   // Address shaping: mostly revisit hot lines (hits), sometimes swap in a
   // new small tag in the same set (conflict misses, evictions), and the
   // rest fully random so every address bit toggles.
   function automatic logic [salct_pkg::ADDR_W-1:0] next_address();
      int unsigned sh, slot, pick;
      logic [63:0] lo_mask, blk_mask, a;
      sh = ((cur_set_bits > 3'd6) ? 6 : cur_set_bits) + cur_block_bits;
      lo_mask = (sh >= 64) ? '1 : ((64'd1 << sh) - 64'd1);
      blk_mask = (64'd1 << cur_block_bits) - 64'd1;
      slot = $urandom_range(0, HOT_SLOTS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         a = 64'(hot_addr[slot]) ^ ({$urandom, $urandom} & blk_mask);
      end else if (pick < 80) begin
         a = (64'(hot_addr[slot]) & lo_mask) | (64'($urandom_range(0, 7)) << sh);
         hot_addr[slot] = a[salct_pkg::ADDR_W-1:0];
      end else begin
         a = 64'(rand_addr());
         hot_addr[slot] = a[salct_pkg::ADDR_W-1:0];
      end
      return a[salct_pkg::ADDR_W-1:0];
   endfunction

   // Offer one item and hold it until the block takes it. A gap, if any,
   // comes first, so valid stays high between back-to-back items.
   task automatic send_access(input logic [1:0] mode,
                              input logic [salct_pkg::ADDR_W-1:0] addr);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == salct_pkg::MODE_IFETCH)
         fetches_sent++;
      else
         accesses_sent++;
   endtask

   // Stop offering, let every expected result come back, then let a fetch
   // still in the pipe clear out.
   task automatic pause_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; caller drops csr_we after the last one
   task automatic csr_write(input logic [salct_pkg::CSR_IDX_W-1:0] idx,
                            input logic [salct_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_geometry(input logic [2:0] s, input logic [5:0] b, input logic [2:0] w);
      pause_until_idle();
      csr_write(salct_pkg::CSR_SET_BITS, 6'(s));
      csr_write(salct_pkg::CSR_BLOCK_BITS, b);
      csr_write(salct_pkg::CSR_WAYS, 6'(w));
      csr_we <= 1'b0;
      cur_set_bits = s;
      cur_block_bits = b;
      geometries++;
   endtask

   initial begin : stimulus
      logic [1:0] mode;
      int         sent_in_phase;
      for (int i = 0; i < HOT_SLOTS; i++)
         hot_addr[i] = rand_addr();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed part, reset geometry (64 sets, 16B, 4 ways)
      req_idle_pct = 27;
      rsp_idle_pct <= 68;
      send_access(MODE_LOAD, 48'h0);                             // cold miss
      send_access(MODE_LOAD, 48'h00F);                           // same block: hit
      send_access(MODE_STORE, 48'hFFFF_FFFF_FFFF);               // all-ones address
      send_access(salct_pkg::MODE_MODIFY, 48'hFFFF_FFFF_FFFF);   // hit plus store half
      send_access(salct_pkg::MODE_MODIFY, 48'h1234_0000_0010);   // modify that misses
      send_access(salct_pkg::MODE_IFETCH, 48'h0);                // no result
      // fill set 0; the fifth tag pushes out the oldest line
      for (int t = 1; t <= 4; t++)
         send_access(MODE_LOAD, 48'(t) << 10);
      send_access(MODE_STORE, 48'h0);                 // miss, evicts again
      send_access(MODE_LOAD, 48'hAAAA_AAAA_AAAA);
      send_access(MODE_STORE, 48'h5555_5555_5555);

      // set bits above the built width, offset of 63 bits, zero ways
      program_geometry(3'd7, 6'd63, 3'd0);
      send_access(MODE_LOAD, 48'h0);
      send_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);     // everything maps to tag 0
      send_access(salct_pkg::MODE_MODIFY, 48'h123);

      // write to the unmapped index must not disturb anything
      pause_until_idle();
      csr_write(CSR_SPARE, 6'h3F);
      csr_we <= 1'b0;

      // single set, direct mapped, tag from the top six bits
      program_geometry(3'd0, 6'd42, 3'd1);
      send_access(MODE_LOAD, 48'h0);
      send_access(MODE_LOAD, 48'h8000_0000_0000);
      send_access(MODE_STORE, 48'h8000_0000_0000);

      // ---------------- random part: three idling regimes, four geometries each
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               req_idle_pct = 27;
               rsp_idle_pct <= 68;
            end
            1: begin
               req_idle_pct = 68;
               rsp_idle_pct <= 27;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            case ((regime * 3 + k) % 8)
               0:       program_geometry(3'd6, 6'd4, 3'd4);   // reset values
               1:       program_geometry(3'd7, 6'd0, 3'd5);   // clamps on both
               2:       program_geometry(3'd0, 6'd42, 3'd1);
               3:       program_geometry(3'd2, 6'd6, 3'd2);
               4:       program_geometry(3'd3, 6'd63, 3'd0);  // set index forced 0
               5:       program_geometry(3'd6, 6'd45, 3'd3);  // tag shifted out
               6:       program_geometry(3'd1, 6'd12, 3'd7);
               default: program_geometry(3'd4, 6'd60, 3'd3);  // offset+set = 64
            endcase
            // back-to-back items against a long result hold-off
            if (regime == 2 && k == 1)
               hold_off_go <= 1'b1;
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ACCESSES) begin
               if ($urandom_range(0, 9) == 0)
                  mode = salct_pkg::MODE_IFETCH;
               else
                  mode = 2'($urandom_range(0, 2));
               send_access(mode, next_address());
               if (mode != salct_pkg::MODE_IFETCH)
                  sent_in_phase++;
            end
         end
      end

      pause_until_idle();

      $display("Covered %0d lookups and %0d instruction fetches over %0d cache geometries,",
               accesses_sent, fetches_sent, geometries);
      $display("with idle sender, idle receiver, full rate and one long result hold-off.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
